/* rtl/core/ipdc_pkg.sv */
// Shared types and constants for the IR pulse duration capture block.
package ipdc_pkg;

  localparam int unsigned DepthDef  = 1024;
  localparam int unsigned DurW      = 31;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CntOutW   = 10;
  localparam int unsigned IdxInW    = 10;
  localparam int unsigned OpW       = 2;
  localparam int unsigned ResW      = StatusW + 1 + CntOutW + DurW + 1;

  localparam logic [DurW-1:0] MaxIdleRst = 31'd30000;

  // capture status codes
  localparam logic [StatusW-1:0] StStopped  = 3'd0;
  localparam logic [StatusW-1:0] StIdle     = 3'd1;
  localparam logic [StatusW-1:0] StRunning  = 3'd2;
  localparam logic [StatusW-1:0] StTimeout  = 3'd3;
  localparam logic [StatusW-1:0] StOverflow = 3'd4;

  // operation codes
  localparam logic [OpW-1:0] OpTick  = 2'd0;
  localparam logic [OpW-1:0] OpRearm = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;
  localparam logic [OpW-1:0] OpNop   = 2'd3;

  // per-word result leaving the control stage
  typedef struct packed {
    logic                  is_read;
    logic                  dur_valid;
    logic [DurW-1:0]       dur;
    logic [CntOutW-1:0]    count;
    logic                  done;
    logic [StatusW-1:0]    status;
  } ipdc_res_t;

  // magnitude of the signed modular difference, saturated to 31 bits
  function automatic logic [DurW-1:0] abs_delta(input logic [31:0] now_v,
                                                input logic [31:0] then_v);
    logic [31:0] diff;
    logic [31:0] neg;
    logic [DurW-1:0] res;
    diff = now_v - then_v;
    neg  = ~diff + 32'd1;
    if (diff[31]) begin
      res = neg[31] ? {DurW{1'b1}} : neg[DurW-1:0];
    end else begin
      res = diff[DurW-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/ipdc_store.sv */
// Duration capture memory: one write port, one registered read port.
module ipdc_store
  import ipdc_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [DurW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [DurW-1:0] rdata_o
);

  logic [DurW-1:0] mem [DEPTH];
  logic [DurW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ipdc_ctrl.sv */
// Capture control: status, edge timing and count; drives memory accesses.
module ipdc_ctrl
  import ipdc_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [OpW-1:0]    op_i,
  input  logic              pin_i,
  input  logic [31:0]       now_i,
  input  logic [IdxInW-1:0] idx_i,
  input  logic [DurW-1:0]   max_idle_i,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [DurW-1:0]   wdata_o,
  output logic              re_o,
  output logic [AW-1:0]     raddr_o,
  output ipdc_res_t         res_o
);

  localparam logic [AW-1:0] LastCount = AW'(DEPTH - 1);

  logic [StatusW-1:0] status_q, status_d;
  logic [31:0]        last_q, last_d;
  logic               prev_q, prev_d;
  logic [AW-1:0]      count_q, count_d;

  logic [DurW-1:0]       delta;
  logic [AW-1:0]         count_inc;
  logic [AW+IdxInW-1:0]  idx_ext;
  logic [AW+IdxInW-1:0]  cnt_ext;
  logic [AW+IdxInW-1:0]  cnt_d_ext;
  logic                  rd_hit;
  logic                  store;

  assign delta     = abs_delta(now_i, last_q);
  assign count_inc = count_q + AW'(1);
  assign idx_ext   = {{AW{1'b0}}, idx_i};
  assign cnt_ext   = {{IdxInW{1'b0}}, count_q};
  assign rd_hit    = idx_ext < cnt_ext;

  always_comb begin
    status_d = status_q;
    last_d   = last_q;
    prev_d   = prev_q;
    count_d  = count_q;
    store    = 1'b0;
    re_o     = 1'b0;
    unique case (op_i)
      OpTick: begin
        if (status_q == StIdle) begin
          if (!pin_i) begin
            status_d = StRunning;
            last_d   = now_i;
            prev_d   = 1'b0;
          end
        end else if (status_q == StRunning) begin
          if (pin_i != prev_q) begin
            store   = 1'b1;
            count_d = count_inc;
            if (count_inc == LastCount) begin
              status_d = StOverflow;
            end else begin
              last_d = now_i;
            end
          end else if (delta > max_idle_i) begin
            store    = 1'b1;
            count_d  = count_inc;
            status_d = StTimeout;
          end
          prev_d = pin_i;
        end
      end
      OpRearm: begin
        count_d  = '0;
        status_d = StIdle;
      end
      OpRead: begin
        re_o = accept_i & rd_hit;
      end
      OpNop: begin
      end
      default: begin
      end
    endcase
  end

  assign we_o    = accept_i & store;
  assign waddr_o = count_q;
  assign wdata_o = delta;
  assign raddr_o = idx_ext[AW-1:0];

  assign cnt_d_ext = {{IdxInW{1'b0}}, count_d};

  always_comb begin
    res_o.is_read   = (op_i == OpRead);
    res_o.dur_valid = store | ((op_i == OpRead) & rd_hit);
    res_o.dur       = store ? delta : '0;
    res_o.count     = cnt_d_ext[CntOutW-1:0];
    res_o.status    = status_d;
    res_o.done      = (status_d == StTimeout) | (status_d == StOverflow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= StStopped;
      last_q   <= '0;
      prev_q   <= 1'b0;
      count_q  <= '0;
    end else if (accept_i) begin
      status_q <= status_d;
      last_q   <= last_d;
      prev_q   <= prev_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/ipdc_outq.sv */
// Three-word output queue decoupling the result stage from the master side.
module ipdc_outq
  import ipdc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [ResW-1:0] wdata_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [ResW-1:0] rdata_o,
  output logic [1:0]      fill_o
);

  localparam logic [1:0] LastSlot = 2'd2;

  logic [ResW-1:0] slot_q [3];
  logic [1:0]      wptr_q, rptr_q, fill_q;
  logic            pop;

  assign valid_o = (fill_q != 2'd0);
  assign pop     = valid_o & ready_i;
  assign rdata_o = slot_q[rptr_q];
  assign fill_o  = fill_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastSlot) ? 2'd0 : wptr_q + 2'd1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LastSlot) ? 2'd0 : rptr_q + 2'd1;
      end
      if (push_i && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/ir_pulse_duration_capture.sv */
// IR pulse duration capture top level: stream ports, config port, result path.
//
// Each input word is one operation on the capture: a sample tick (line level
// plus microsecond timestamp), a rearm, or a read of a stored duration. After
// a rearm the block waits for the line to go low, then stores the time
// between level changes into a DEPTH-entry duration memory until the line
// stays quiet longer than max_idle_us (timeout, final gap stored) or
// DEPTH-1 durations are held (overflow). Deltas are the magnitude of the
// signed modular 32-bit timestamp difference, saturated at 2^31-1. Every
// input word yields exactly one output word carrying status, done flag,
// count and the duration stored or read. One word is accepted every clock
// cycle while the output queue has room; each result is registered in the
// result stage beside the registered memory read port, then in the output
// queue. A three-word output queue keeps the slave side taking words
// while results wait on the master side. The memory needs no clearing after
// reset: only entries below the count are ever read. max_idle_us lives at
// APB byte address 0 and resets to 30000; write it only while idle.
module ir_pulse_duration_capture
  import ipdc_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // pin_level[0], now_us[32:1], read_index[42:33]
  input  logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // capture_status[2:0], capture_done[3],
                                       // entry_count[13:4], duration_us[44:14],
                                       // duration_valid[45]
  // config port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // config register
  logic [DurW-1:0] max_idle_q;
  logic            cfg_hit;

  assign pready_o = 1'b1;
  assign cfg_hit  = (paddr_i[2] == 1'b0);
  assign prdata_o = cfg_hit ? {1'b0, max_idle_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_idle_q <= MaxIdleRst;
    end else if (psel_i && penable_i && pwrite_i && cfg_hit) begin
      max_idle_q <= pwdata_i[DurW-1:0];
    end
  end

  // input handshake
  logic       accept;
  logic [1:0] q_fill;
  logic       s1_valid_q;
  logic [2:0] pending;

  // room check counts the word in the result stage; queue holds up to three
  assign pending         = {1'b0, q_fill} + {2'b0, s1_valid_q};
  assign s_axis_tready_o = (pending <= 3'd2);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // control and memory
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [DurW-1:0] wdata, rdata;
  ipdc_res_t       res;

  ipdc_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (s_axis_tuser_i),
    .pin_i     (s_axis_tdata_i[0]),
    .now_i     (s_axis_tdata_i[32:1]),
    .idx_i     (s_axis_tdata_i[42:33]),
    .max_idle_i(max_idle_q),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .re_o      (re),
    .raddr_o   (raddr),
    .res_o     (res)
  );

  ipdc_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // result stage: lines up with the memory read data
  ipdc_res_t       s1_q;
  logic [DurW-1:0] s1_dur;
  logic [ResW-1:0] s1_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
  end

  // read words take the memory data; a miss reads as zero
  assign s1_dur  = s1_q.is_read ? (s1_q.dur_valid ? rdata : '0) : s1_q.dur;
  assign s1_word = {s1_q.dur_valid, s1_dur, s1_q.count, s1_q.done, s1_q.status};

  logic [ResW-1:0] q_word;

  ipdc_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_valid_q),
    .wdata_i(s1_word),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .rdata_o(q_word),
    .fill_o (q_fill)
  );

  assign m_axis_tdata_o = {{(48 - ResW){1'b0}}, q_word};

endmodule
